FILE: rtl/mbef_pkg.sv
// Shared constants, operation and status codes, and the cell control bundle
// for the mesh boundary edge finder. No dependencies.
package mbef_pkg;

   localparam int FIELD_BITS  = 16;
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;
   localparam int CNT_BITS    = 2;
   localparam int OR_GROUP    = 32;

   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_BITS-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_FETCH = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_DROPPED = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EDGE    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_NO_MORE = 2'd3;

   localparam logic [CNT_BITS-1:0] CNT_ONE = 2'd1;
   localparam logic [CNT_BITS-1:0] CNT_TWO = 2'd2;

   typedef struct packed {
      logic clear;
      logic compare;
      logic apply;
      logic found;
      logic full;
      logic rotate;
   } cell_ctl_type;

endpackage

FILE: rtl/mbef_intf.sv
// Request and response channel interfaces (valid/ready) for the edge finder.
// Depends on mbef_pkg.
interface mbef_req_if;
   import mbef_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    operation;
   logic [FIELD_BITS-1:0] vertex_a;
   logic [FIELD_BITS-1:0] vertex_b;
   logic [FIELD_BITS-1:0] vertex_c;

   modport source (output valid, operation, vertex_a, vertex_b, vertex_c, input ready);
   modport sink   (input valid, operation, vertex_a, vertex_b, vertex_c, output ready);
endinterface

interface mbef_rsp_if;
   import mbef_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [FIELD_BITS-1:0]  edge_low;
   logic [FIELD_BITS-1:0]  edge_high;

   modport source (output valid, status, edge_low, edge_high, input ready);
   modport sink   (input valid, status, edge_low, edge_high, output ready);
endinterface

FILE: rtl/mbef_cell.sv
// One cell of the sorted edge chain: holds one entry and its compare flags,
// shifts from its left neighbor on insert and from its right one on rotate.
// Depends on mbef_pkg.
module mbef_cell #(
   parameter int VERTEX_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mbef_pkg::cell_ctl_type        ctrl,
   input  logic [VERTEX_BITS-1:0]        new_lo,
   input  logic [VERTEX_BITS-1:0]        new_hi,
   input  logic                          left_valid,
   input  logic                          left_gt,
   input  logic [VERTEX_BITS-1:0]        left_lo,
   input  logic [VERTEX_BITS-1:0]        left_hi,
   input  logic [mbef_pkg::CNT_BITS-1:0] left_cnt,
   input  logic                          right_valid,
   input  logic [VERTEX_BITS-1:0]        right_lo,
   input  logic [VERTEX_BITS-1:0]        right_hi,
   input  logic [mbef_pkg::CNT_BITS-1:0] right_cnt,
   input  logic [VERTEX_BITS-1:0]        head_lo,
   input  logic [VERTEX_BITS-1:0]        head_hi,
   input  logic [mbef_pkg::CNT_BITS-1:0] head_cnt,
   output logic                          valid,
   output logic [VERTEX_BITS-1:0]        lo,
   output logic [VERTEX_BITS-1:0]        hi,
   output logic [mbef_pkg::CNT_BITS-1:0] cnt,
   output logic                          gt,
   output logic                          eq
);
   import mbef_pkg::*;

   logic                   valid_ff, valid_in;
   logic                   gt_ff, gt_in;
   logic                   eq_ff, eq_in;
   logic [VERTEX_BITS-1:0] lo_ff, lo_in;
   logic [VERTEX_BITS-1:0] hi_ff, hi_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   key_gt, key_eq;

   assign key_gt = {lo_ff, hi_ff} > {new_lo, new_hi};
   assign key_eq = {lo_ff, hi_ff} == {new_lo, new_hi};

   always_comb begin
      valid_in = valid_ff;
      gt_in    = gt_ff;
      eq_in    = eq_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      cnt_in   = cnt_ff;
      if (ctrl.compare) begin
         gt_in = !valid_ff || key_gt;
         eq_in = valid_ff && key_eq;
      end
      if (ctrl.apply) begin
         if (ctrl.found) begin
            if (eq_ff) begin
               cnt_in = CNT_TWO;
            end
         end else if (!ctrl.full) begin
            if (left_gt) begin
               valid_in = left_valid;
               lo_in    = left_lo;
               hi_in    = left_hi;
               cnt_in   = left_cnt;
            end else if (gt_ff) begin
               valid_in = 1'b1;
               lo_in    = new_lo;
               hi_in    = new_hi;
               cnt_in   = CNT_ONE;
            end
         end
      end
      // rotate the occupied part by one, head wraps to the last occupied cell
      if (ctrl.rotate) begin
         if (right_valid) begin
            lo_in  = right_lo;
            hi_in  = right_hi;
            cnt_in = right_cnt;
         end else if (valid_ff) begin
            lo_in  = head_lo;
            hi_in  = head_hi;
            cnt_in = head_cnt;
         end
      end
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         valid_ff <= 1'b0;
         gt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         gt_ff    <= gt_in;
         eq_ff    <= eq_in;
      end
   end

   assign valid = valid_ff;
   assign lo    = lo_ff;
   assign hi    = hi_ff;
   assign cnt   = cnt_ff;
   assign gt    = gt_ff;
   assign eq    = eq_ff;

endmodule

FILE: rtl/mbef_eq_reduce.sv
// Registered OR tree over the per-cell match flags: one register level of
// group ORs, then a final OR of the groups. Depends on mbef_pkg.
module mbef_eq_reduce #(
   parameter int CELLS = 1024
) (
   input  logic             clock,
   input  logic [CELLS-1:0] eq,
   output logic             found
);
   import mbef_pkg::*;

   localparam int Groups  = (CELLS + OR_GROUP - 1) / OR_GROUP;
   localparam int PadBits = Groups * OR_GROUP;

   logic [PadBits-1:0] eq_pad;
   logic [Groups-1:0]  grp_ff, grp_in;

   assign eq_pad = PadBits'(eq);

   always_comb begin
      for (int g = 0; g < Groups; g++) begin
         grp_in[g] = |eq_pad[g*OR_GROUP +: OR_GROUP];
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign found = |grp_ff;

endmodule

FILE: rtl/mesh_boundary_edge_finder.sv
// Mesh boundary edge finder: sorted chain of edge cells with use counts,
// a registered match-reduction tree and an operation sequencer.
// Depends on mbef_pkg, mbef_intf, mbef_cell and mbef_eq_reduce.
//
// Each request is one operation: clear, add a triangle, or fetch the next
// boundary edge; each gives exactly one response. Edges live in a chain of
// MAX_EDGES cells kept sorted by (low, high) vertex with a use count that
// saturates at two. An edge is inserted in the compare, reduce and apply
// states: every cell compares itself with the key, the match flags go
// through a registered OR tree, then the chain either bumps the matching
// count, shifts right by one from the insertion point, or, when the last
// cell is occupied, drops the edge and flags the add as dropped. Fetch walks
// the table by rotating the occupied cells left by one per cycle; the first
// add after a partial fetch walk first rotates the rest of the way round.
// Every operation then passes the done state, which waits for a free output
// register, and returns to idle before the next request is accepted. The
// cells' valid bits clear at reset, so no clearing pass is needed. A new
// request is accepted while the previous response still waits in the output
// register.
module mesh_boundary_edge_finder #(
   parameter int MAX_EDGES   = 1024,
   parameter int VERTEX_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mbef_req_if.sink   req_bus,
   mbef_rsp_if.source rsp_bus
);
   import mbef_pkg::*;

   localparam int                  PosBits   = $clog2(MAX_EDGES + 1);
   localparam logic [PosBits-1:0]  FullCount = PosBits'(MAX_EDGES);
   localparam logic [1:0]          EdgeFirst = 2'd0;
   localparam logic [1:0]          EdgeMid   = 2'd1;
   localparam logic [1:0]          EdgeLast  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_RESTORE, S_CMP, S_RED, S_APPLY, S_FETCH, S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             edge_idx_ff, edge_idx_in;
   logic [VERTEX_BITS-1:0] va_ff, va_in, vb_ff, vb_in, vc_ff, vc_in;
   logic [PosBits-1:0]     count_ff, count_in;
   logic [PosBits-1:0]     pos_ff, pos_in;
   logic                   ovf_ff, ovf_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic [VERTEX_BITS-1:0] res_lo_ff, res_lo_in, res_hi_ff, res_hi_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [FIELD_BITS-1:0]  rsp_lo_ff, rsp_lo_in, rsp_hi_ff, rsp_hi_in;

   logic                   accept;
   logic [PosBits-1:0]     pos_inc;
   logic [VERTEX_BITS-1:0] v0, v1, new_lo, new_hi;
   logic                   found;
   cell_ctl_type           ctrl;

   logic                   cell_valid [MAX_EDGES];
   logic [VERTEX_BITS-1:0] cell_lo    [MAX_EDGES];
   logic [VERTEX_BITS-1:0] cell_hi    [MAX_EDGES];
   logic [CNT_BITS-1:0]    cell_cnt   [MAX_EDGES];
   logic [MAX_EDGES-1:0]   cell_gt;
   logic [MAX_EDGES-1:0]   cell_eq;

   // edges of the triangle: (a,b), (b,c), (c,a)
   always_comb begin
      case (edge_idx_ff)
         EdgeFirst: begin
            v0 = va_ff;
            v1 = vb_ff;
         end
         EdgeMid: begin
            v0 = vb_ff;
            v1 = vc_ff;
         end
         default: begin
            v0 = vc_ff;
            v1 = va_ff;
         end
      endcase
      new_lo = (v0 < v1) ? v0 : v1;
      new_hi = (v0 < v1) ? v1 : v0;
   end

   assign ctrl.clear   = state_ff == S_CLEAR;
   assign ctrl.compare = state_ff == S_CMP;
   assign ctrl.apply   = state_ff == S_APPLY;
   assign ctrl.found   = found;
   assign ctrl.full    = cell_valid[MAX_EDGES-1];
   assign ctrl.rotate  = (state_ff == S_RESTORE) ||
                         ((state_ff == S_FETCH) && (pos_ff < count_ff));

   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
      logic                   l_valid, l_gt, r_valid;
      logic [VERTEX_BITS-1:0] l_lo, l_hi, r_lo, r_hi;
      logic [CNT_BITS-1:0]    l_cnt, r_cnt;

      if (i == 0) begin : g_first
         assign l_valid = 1'b0;
         assign l_gt    = 1'b0;
         assign l_lo    = '0;
         assign l_hi    = '0;
         assign l_cnt   = '0;
      end else begin : g_inner
         assign l_valid = cell_valid[i-1];
         assign l_gt    = cell_gt[i-1];
         assign l_lo    = cell_lo[i-1];
         assign l_hi    = cell_hi[i-1];
         assign l_cnt   = cell_cnt[i-1];
      end

      if (i == MAX_EDGES - 1) begin : g_last
         assign r_valid = 1'b0;
         assign r_lo    = '0;
         assign r_hi    = '0;
         assign r_cnt   = '0;
      end else begin : g_body
         assign r_valid = cell_valid[i+1];
         assign r_lo    = cell_lo[i+1];
         assign r_hi    = cell_hi[i+1];
         assign r_cnt   = cell_cnt[i+1];
      end

      mbef_cell #(
         .VERTEX_BITS(VERTEX_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_lo      (new_lo),
         .new_hi      (new_hi),
         .left_valid  (l_valid),
         .left_gt     (l_gt),
         .left_lo     (l_lo),
         .left_hi     (l_hi),
         .left_cnt    (l_cnt),
         .right_valid (r_valid),
         .right_lo    (r_lo),
         .right_hi    (r_hi),
         .right_cnt   (r_cnt),
         .head_lo     (cell_lo[0]),
         .head_hi     (cell_hi[0]),
         .head_cnt    (cell_cnt[0]),
         .valid       (cell_valid[i]),
         .lo          (cell_lo[i]),
         .hi          (cell_hi[i]),
         .cnt         (cell_cnt[i]),
         .gt          (cell_gt[i]),
         .eq          (cell_eq[i])
      );
   end

   mbef_eq_reduce #(
      .CELLS(MAX_EDGES)
   ) u_reduce (
      .clock (clock),
      .eq    (cell_eq),
      .found (found)
   );

   assign req_bus.ready = state_ff == S_IDLE;
   assign accept        = req_bus.valid && req_bus.ready;
   assign pos_inc       = pos_ff + PosBits'(1);

   always_comb begin
      state_in      = state_ff;
      edge_idx_in   = edge_idx_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      vc_in         = vc_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      ovf_in        = ovf_ff;
      res_status_in = res_status_ff;
      res_lo_in     = res_lo_ff;
      res_hi_in     = res_hi_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_lo_in     = rsp_lo_ff;
      rsp_hi_in     = rsp_hi_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_lo_in = '0;
               res_hi_in = '0;
               case (req_bus.operation)
                  OP_CLEAR: begin
                     state_in = S_CLEAR;
                  end
                  OP_ADD: begin
                     va_in       = VERTEX_BITS'(req_bus.vertex_a);
                     vb_in       = VERTEX_BITS'(req_bus.vertex_b);
                     vc_in       = VERTEX_BITS'(req_bus.vertex_c);
                     edge_idx_in = EdgeFirst;
                     if ((pos_ff == '0) || (pos_ff == count_ff)) begin
                        pos_in   = '0;
                        state_in = S_CMP;
                     end else begin
                        state_in = S_RESTORE;
                     end
                  end
                  OP_FETCH: begin
                     state_in = S_FETCH;
                  end
                  default: begin
                     res_status_in = ST_OK;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            count_in      = '0;
            pos_in        = '0;
            ovf_in        = 1'b0;
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end
         S_RESTORE: begin
            pos_in = pos_inc;
            if (pos_inc == count_ff) begin
               pos_in   = '0;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_RED;
         end
         S_RED: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (!found) begin
               if (ctrl.full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + PosBits'(1);
               end
            end
            if (edge_idx_ff == EdgeLast) begin
               res_status_in = ovf_in ? ST_DROPPED : ST_OK;
               state_in      = S_DONE;
            end else begin
               edge_idx_in = edge_idx_ff + 2'd1;
               state_in    = S_CMP;
            end
         end
         S_FETCH: begin
            if (pos_ff == count_ff) begin
               res_status_in = ST_NO_MORE;
               state_in      = S_DONE;
            end else begin
               pos_in = pos_inc;
               if (cell_cnt[0] == CNT_ONE) begin
                  res_status_in = ST_EDGE;
                  res_lo_in     = cell_lo[0];
                  res_hi_in     = cell_hi[0];
                  state_in      = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_lo_in     = FIELD_BITS'(res_lo_ff);
               rsp_hi_in     = FIELD_BITS'(res_hi_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      vc_ff         <= vc_in;
      res_status_ff <= res_status_in;
      res_lo_ff     <= res_lo_in;
      res_hi_ff     <= res_hi_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_hi_ff     <= rsp_hi_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         edge_idx_ff  <= EdgeFirst;
         count_ff     <= '0;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edge_idx_ff  <= edge_idx_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.edge_low  = rsp_lo_ff;
   assign rsp_bus.edge_high = rsp_hi_ff;

   a_full_tracks_count: assert property (@(posedge clock) disable iff (reset)
      cell_valid[MAX_EDGES-1] == (count_ff == FullCount))
      else $error("last cell occupancy disagrees with entry count");

   a_pos_within_count: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= count_ff)
      else $error("fetch position beyond entry count");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      !cell_valid[0] |-> (count_ff == '0))
      else $error("head cell empty with entries counted");

endmodule
